>>> src/multi_pipe_byte_fifo_top_assert.svh
`ifndef MULTI_PIPE_BYTE_FIFO_TOP_ASSERT_SVH
`define MULTI_PIPE_BYTE_FIFO_TOP_ASSERT_SVH

// These checks are clocked by i_clk and held off while i_rst_n is low,
// so the including module must have both signals.

// Check that holds on every cycle out of reset.
`define MPBF_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("mpbf assertion failed");

// Check that a condition implies another in the same cycle.
`define MPBF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mpbf assertion failed");

// Check that a condition implies another in the next cycle.
`define MPBF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mpbf assertion failed");

`endif

>>> src/mpbf_pkg.sv
package mpbf_pkg;

    localparam int REQ_W    = 3;
    localparam int IDX_W    = 3;
    localparam int DATA_W   = 8;
    localparam int STATUS_W = 3;

    typedef logic [REQ_W-1:0]    t_req_type;
    typedef logic [IDX_W-1:0]    t_pipe_idx;
    typedef logic [DATA_W-1:0]   t_byte;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_req_type REQ_CREATE   = 3'd0;
    localparam t_req_type REQ_WRITE    = 3'd1;
    localparam t_req_type REQ_READ     = 3'd2;
    localparam t_req_type REQ_CLOSE_RD = 3'd3;
    localparam t_req_type REQ_CLOSE_WR = 3'd4;

    localparam t_status ST_OK         = 3'd0;
    localparam t_status ST_INVALID    = 3'd1;
    localparam t_status ST_FULL       = 3'd2;
    localparam t_status ST_EMPTY      = 3'd3;
    localparam t_status ST_TABLE_FULL = 3'd4;

endpackage

>>> src/mpbf_if.sv
interface mpbf_req_if;
    logic                  valid;
    logic                  ready;
    mpbf_pkg::t_req_type   req_type;
    mpbf_pkg::t_pipe_idx   pipe_index;
    mpbf_pkg::t_byte       data_in;
    logic                  burst_last;

    modport source (output valid, req_type, pipe_index, data_in, burst_last, input ready);
    modport sink   (input valid, req_type, pipe_index, data_in, burst_last, output ready);
endinterface

interface mpbf_rsp_if;
    logic                  valid;
    logic                  ready;
    mpbf_pkg::t_status     status;
    mpbf_pkg::t_pipe_idx   new_index;
    mpbf_pkg::t_byte       read_data;
    logic                  writer_open;
    logic                  last_out;

    modport source (output valid, status, new_index, read_data, writer_open, last_out,
                    input ready);
    modport sink   (input valid, status, new_index, read_data, writer_open, last_out,
                    output ready);
endinterface

>>> src/multi_pipe_byte_fifo_top.sv
// Channel   Direction  Payload
// i_req     in         req_type, pipe_index, data_in, burst_last
// o_rsp     out        status, new_index, read_data, writer_open, last_out
//
// One request per clock while o_rsp is not stalled: each accepted request gives its response in the next cycle.
// The byte store is a single-port memory with a registered read; pipe state is in flops.
// A request is taken whenever the response register is empty or being drained.
// Reset clears the pipe table; the byte store needs no clearing pass.
`include "multi_pipe_byte_fifo_top_assert.svh"

module multi_pipe_byte_fifo_top #(
    parameter int NUM_PIPES  = 8,
    parameter int RING_BYTES = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mpbf_req_if.sink         i_req,
    mpbf_rsp_if.source       o_rsp
);

    localparam int PIPE_W  = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int CNT_W   = $clog2(NUM_PIPES + 1);
    localparam int CMP_W   = (CNT_W > mpbf_pkg::IDX_W) ? CNT_W : mpbf_pkg::IDX_W;
    localparam int SEL_W   = (PIPE_W > mpbf_pkg::IDX_W) ? PIPE_W : mpbf_pkg::IDX_W;
    localparam int PTR_W   = $clog2(RING_BYTES);
    localparam int FILL_W  = $clog2(RING_BYTES + 1);
    localparam int ADDR_W  = PIPE_W + PTR_W;
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(RING_BYTES - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RING_BYTES);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(NUM_PIPES);

    // Pipe table.
    logic [CNT_W-1:0]  r_pipes_in_use;
    logic [PTR_W-1:0]  r_rd_ptr  [NUM_PIPES];
    logic [PTR_W-1:0]  r_wr_ptr  [NUM_PIPES];
    logic [FILL_W-1:0] r_fill    [NUM_PIPES];
    logic              r_rd_open [NUM_PIPES];
    logic              r_wr_open [NUM_PIPES];

    logic [7:0] r_mem [MEM_DEPTH];
    logic [7:0] r_mem_q;

    // Response register.
    logic                r_out_valid;
    mpbf_pkg::t_status   r_status;
    mpbf_pkg::t_pipe_idx r_new_index;
    logic                r_rd_ok;
    logic                r_wopen;
    logic                r_last;

    logic                w_acc;
    logic [SEL_W-1:0]    w_idx_ext;
    logic [PIPE_W-1:0]   w_sel;
    logic [PIPE_W-1:0]   w_new_sel;
    logic                w_exists;
    logic                w_room;
    logic [PTR_W-1:0]    w_rp;
    logic [PTR_W-1:0]    w_wp;
    logic [FILL_W-1:0]   w_fill;
    logic                w_wflag;
    logic [CNT_W-1:0]    w_pipes_inc;

    mpbf_pkg::t_status   n_status;
    mpbf_pkg::t_pipe_idx n_new_index;
    logic                n_rd_ok;
    logic                n_wopen;
    logic                n_do_create;
    logic                n_do_write;
    logic                n_close_rd;
    logic                n_close_wr;
    logic [ADDR_W-1:0]   n_addr;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_acc       = i_req.valid && i_req.ready;

    assign w_idx_ext = SEL_W'(i_req.pipe_index);
    assign w_sel     = w_idx_ext[PIPE_W-1:0];
    assign w_new_sel = r_pipes_in_use[PIPE_W-1:0];
    assign w_exists  = CMP_W'(i_req.pipe_index) < CMP_W'(r_pipes_in_use);
    assign w_room    = r_pipes_in_use != CNT_FULL;
    assign w_pipes_inc = r_pipes_in_use + 1'b1;

    assign w_rp    = r_rd_ptr[w_sel];
    assign w_wp    = r_wr_ptr[w_sel];
    assign w_fill  = r_fill[w_sel];
    assign w_wflag = r_wr_open[w_sel];

    always_comb begin
        n_status    = mpbf_pkg::ST_INVALID;
        n_new_index = '0;
        n_rd_ok     = 1'b0;
        n_wopen     = 1'b0;
        n_do_create = 1'b0;
        n_do_write  = 1'b0;
        n_close_rd  = 1'b0;
        n_close_wr  = 1'b0;
        case (i_req.req_type)
            mpbf_pkg::REQ_CREATE: begin
                if (!w_room) begin
                    n_status = mpbf_pkg::ST_TABLE_FULL;
                end else begin
                    n_status    = mpbf_pkg::ST_OK;
                    n_new_index = mpbf_pkg::IDX_W'(r_pipes_in_use);
                    n_wopen     = 1'b1;
                    n_do_create = 1'b1;
                end
            end
            mpbf_pkg::REQ_WRITE: begin
                if (w_exists) begin
                    n_wopen = w_wflag;
                    if (!w_wflag) begin
                        n_status = mpbf_pkg::ST_INVALID;
                    end else if (w_fill == FILL_FULL) begin
                        n_status = mpbf_pkg::ST_FULL;
                    end else begin
                        n_status   = mpbf_pkg::ST_OK;
                        n_do_write = 1'b1;
                    end
                end
            end
            mpbf_pkg::REQ_READ: begin
                if (w_exists) begin
                    n_wopen = w_wflag;
                    if (w_fill == '0) begin
                        n_status = mpbf_pkg::ST_EMPTY;
                    end else begin
                        n_status = mpbf_pkg::ST_OK;
                        n_rd_ok  = 1'b1;
                    end
                end
            end
            mpbf_pkg::REQ_CLOSE_RD: begin
                if (w_exists) begin
                    n_status   = mpbf_pkg::ST_OK;
                    n_wopen    = w_wflag;
                    n_close_rd = 1'b1;
                end
            end
            mpbf_pkg::REQ_CLOSE_WR: begin
                if (w_exists) begin
                    n_status   = mpbf_pkg::ST_OK;
                    n_wopen    = 1'b0;
                    n_close_wr = 1'b1;
                end
            end
            default: begin
                n_status = mpbf_pkg::ST_INVALID;
            end
        endcase
        n_addr = n_do_write ? {w_sel, w_wp} : {w_sel, w_rp};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipes_in_use <= '0;
            for (int p = 0; p < NUM_PIPES; p++) begin
                r_rd_ptr[p]  <= '0;
                r_wr_ptr[p]  <= '0;
                r_fill[p]    <= '0;
                r_rd_open[p] <= 1'b0;
                r_wr_open[p] <= 1'b0;
            end
        end else if (w_acc) begin
            if (n_do_create) begin
                r_pipes_in_use       <= r_pipes_in_use + 1'b1;
                r_rd_ptr[w_new_sel]  <= '0;
                r_wr_ptr[w_new_sel]  <= '0;
                r_fill[w_new_sel]    <= '0;
                r_rd_open[w_new_sel] <= 1'b1;
                r_wr_open[w_new_sel] <= 1'b1;
            end
            if (n_do_write) begin
                r_wr_ptr[w_sel] <= (w_wp == PTR_LAST) ? '0 : w_wp + 1'b1;
                r_fill[w_sel]   <= w_fill + 1'b1;
            end
            if (n_rd_ok) begin
                r_rd_ptr[w_sel] <= (w_rp == PTR_LAST) ? '0 : w_rp + 1'b1;
                r_fill[w_sel]   <= w_fill - 1'b1;
            end
            if (n_close_rd) begin
                r_rd_open[w_sel] <= 1'b0;
            end
            if (n_close_wr) begin
                r_wr_open[w_sel] <= 1'b0;
            end
        end
    end

    // Byte store: one access per request, read data registered.
    always_ff @(posedge i_clk) begin
        if (w_acc && n_do_write) begin
            r_mem[n_addr] <= i_req.data_in;
        end
        if (w_acc && n_rd_ok) begin
            r_mem_q <= r_mem[n_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status    <= n_status;
            r_new_index <= n_new_index;
            r_rd_ok     <= n_rd_ok;
            r_wopen     <= n_wopen;
            r_last      <= i_req.burst_last;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.new_index   = r_new_index;
    assign o_rsp.read_data   = r_rd_ok ? r_mem_q : 8'd0;
    assign o_rsp.writer_open = r_wopen;
    assign o_rsp.last_out    = r_last;

    `MPBF_ASSERT_ALWAYS(a_table_bound, r_pipes_in_use <= CNT_FULL)
    `MPBF_ASSERT_SAME(a_stall_blocks_input, r_out_valid && !o_rsp.ready, !i_req.ready)
    `MPBF_ASSERT_SAME(a_read_data_ok, r_out_valid && r_rd_ok, r_status == mpbf_pkg::ST_OK)
    `MPBF_ASSERT_NEXT(a_create_counts, w_acc && n_do_create, r_pipes_in_use == $past(w_pipes_inc))

endmodule
